### sv/pla_pkg.sv
`default_nettype none
package pla_pkg;

  localparam int unsigned MaxLightsDefault = 8;
  localparam int unsigned CoordW = 24;
  localparam int unsigned LevelW = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned SqW = 50;
  localparam int unsigned DiffW = 25;
  localparam int unsigned ProdW = 40;
  localparam logic [LevelW-1:0] OneLevel = 16'd32768;
  localparam logic [LevelW-1:0] AmbientReset = 16'd8192;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic [0:0] RegAmbient = 1'd0;
  localparam logic [0:0] RegLightsInUse = 1'd1;

  typedef struct packed {
    logic              kind;
    logic [2:0]        light_index;
    logic signed [23:0] light_x;
    logic signed [23:0] light_y;
    logic [23:0]       light_radius;
    logic [15:0]       light_intensity;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } item_t;

  typedef struct packed {
    logic [15:0] brightness;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic [SqW-1:0]    sq;
    logic [CoordW-1:0] radius;
    logic [LevelW-1:0] intensity;
  } term_req_t;

endpackage
`default_nettype wire

### sv/pla_serial_mul.sv
`default_nettype none
module pla_serial_mul #(
  parameter int unsigned AW = 25,
  parameter int unsigned BW = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      product
);
  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc;
  logic [BW-1:0]    mplier;
  logic [AW+BW-1:0] mcand;
  logic [CW-1:0]    count;
  logic             running;

  assign product = acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      count <= '0;
    end else if (start) begin
      running <= 1'b1;
      acc <= '0;
      mplier <= b;
      mcand <= {{BW{1'b0}}, a};
      count <= CW'(BW);
    end else if (running) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mplier <= mplier >> 1;
      mcand <= mcand << 1;
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### sv/pla_term_unit.sv
`default_nettype none
module pla_term_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire pla_pkg::term_req_t   req,
  output logic                      done,
  output logic [pla_pkg::LevelW-1:0] term
);
  import pla_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE, T_RSQ, T_SQRT, T_MUL, T_DIV, T_DONE
  } tstate_t;

  tstate_t state;
  logic [SqW-1:0] sq;
  logic [CoordW-1:0] r;
  logic [LevelW-1:0] inten;
  logic [5:0] cnt;

  logic mul_start, mul_done;
  logic [DiffW-1:0] ma, mb;
  logic [2*DiffW-1:0] mprod;

  // sqrt: two bits per step
  logic [SqW-1:0] rem;
  logic [SqW-1:0] rt;
  logic [SqW-1:0] bitv;

  // division: restoring, one quotient bit per step
  logic [ProdW-1:0] num;
  logic [CoordW:0] part;
  logic [LevelW-1:0] quo;

  logic [CoordW:0] part_sh;
  assign part_sh = {part[CoordW-1:0], num[ProdW-1]};

  pla_serial_mul #(.AW(DiffW), .BW(DiffW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(ma), .b(mb),
    .done(mul_done), .product(mprod)
  );

  assign term = quo;

  always_ff @(posedge clk) begin
    mul_start <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            sq <= req.sq;
            r <= req.radius;
            inten <= req.intensity;
            ma <= {1'b0, req.radius};
            mb <= {1'b0, req.radius};
            mul_start <= 1'b1;
            state <= T_RSQ;
          end
        end
        T_RSQ: begin
          if (mul_done) begin
            if (r == '0 || {1'b0, sq} >= {1'b0, mprod[SqW-1:0]}) begin
              quo <= '0;
              done <= 1'b1;
              state <= T_IDLE;
            end else begin
              rem <= sq;
              rt <= '0;
              bitv <= SqW'(1) << (SqW - 2);
              cnt <= 6'(SqW / 2);
              state <= T_SQRT;
            end
          end
        end
        T_SQRT: begin
          if (rem >= rt + bitv) begin
            rem <= rem - (rt + bitv);
            rt <= (rt >> 1) + bitv;
          end else begin
            rt <= rt >> 1;
          end
          bitv <= bitv >> 2;
          cnt <= cnt - 1'b1;
          if (cnt == 6'd1) begin
            state <= T_MUL;
          end
        end
        T_MUL: begin
          // sq < r*r so rt < r, and d = r - rt fits in 24 bits
          ma <= {1'b0, r - rt[CoordW-1:0]};
          mb <= {{(DiffW-LevelW){1'b0}}, inten};
          mul_start <= 1'b1;
          cnt <= 6'(ProdW);
          part <= '0;
          quo <= '0;
          state <= T_DIV;
        end
        T_DIV: begin
          if (mul_start == 1'b0 && cnt == 6'(ProdW) && !mul_done) begin
            state <= T_DIV;
          end
          if (mul_done) begin
            num <= mprod[ProdW-1:0];
            state <= T_DONE;
          end
        end
        T_DONE: begin
          if (part_sh >= {1'b0, r}) begin
            part <= part_sh - {1'b0, r};
            quo <= {quo[LevelW-2:0], 1'b1};
          end else begin
            part <= part_sh;
            quo <= {quo[LevelW-2:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt - 1'b1;
          if (cnt == 6'd1) begin
            done <= 1'b1;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/point_light_accumulator.sv
`default_nettype none
// point light accumulator
// start with busy low transfers one item on the item port. a write item
// (kind 0) with light_index below MAX_LIGHTS loads one table entry and
// gives no result. a query item (kind 1) walks the first
// min(lights_in_use, MAX_LIGHTS) entries, one at a time, and adds each
// light's falloff term to ambient_level. the result appears on result
// with result_valid high for exactly one cycle; the receiver cannot
// stall, so the result must be taken in that cycle.
// per light: table read, serial squares of dx and dy, serial r*r, a
// two-bit-per-step square root, a serial multiply and a restoring divide;
// the root, multiply and divide are skipped when the point is out of
// reach or the radius is zero. one item at a time: busy stays high from
// the transfer until the result strobe.
// config writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. reset sets ambient_level to 8192, lights_in_use
// to 0 and returns the control to idle; table contents are undefined
// until written.
module point_light_accumulator #(
  parameter int unsigned MAX_LIGHTS = pla_pkg::MaxLightsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire pla_pkg::item_t      item,
  output logic                     result_valid,
  output pla_pkg::result_t         result,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import pla_pkg::*;

  localparam int unsigned IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned NW = $clog2(MAX_LIGHTS + 1) > CountW ?
                               $clog2(MAX_LIGHTS + 1) : CountW;

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_DX, S_SQX, S_DY, S_TERM, S_OUT
  } state_t;

  logic [LevelW-1:0] ambient_level;
  logic [CountW-1:0] lights_in_use;

  logic [CoordW-1:0] x_mem [MAX_LIGHTS];
  logic [CoordW-1:0] y_mem [MAX_LIGHTS];
  logic [CoordW-1:0] r_mem [MAX_LIGHTS];
  logic [LevelW-1:0] i_mem [MAX_LIGHTS];

  state_t state;
  logic [NW-1:0] idx;
  logic [NW-1:0] n_lights;
  logic signed [CoordW-1:0] px, py;
  logic [CoordW-1:0] lx, ly, lr;
  logic [LevelW-1:0] li;
  logic [LevelW+IW+1:0] sum;
  logic [SqW-1:0] sq;
  logic rd_pending;

  logic mul_start, mul_done;
  logic [DiffW-1:0] mul_a;
  logic [2*DiffW-1:0] mul_p;
  logic term_start, term_done;
  logic [LevelW-1:0] term;
  term_req_t term_req;

  logic signed [DiffW-1:0] dx, dy;
  assign dx = DiffW'(px) - DiffW'($signed(lx));
  assign dy = DiffW'(py) - DiffW'($signed(ly));

  pla_serial_mul #(.AW(DiffW), .BW(DiffW)) u_sqr (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_a),
    .done(mul_done), .product(mul_p)
  );

  assign term_req = '{sq: sq, radius: lr, intensity: li};

  pla_term_unit u_term (
    .clk(clk), .rst(rst), .start(term_start), .req(term_req),
    .done(term_done), .term(term)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        RegAmbient: ambient_level <= cfg_data;
        RegLightsInUse: lights_in_use <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
    if (rst) begin
      ambient_level <= AmbientReset;
      lights_in_use <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && item.kind == KindWrite &&
        32'(item.light_index) < MAX_LIGHTS) begin
      x_mem[IW'(item.light_index)] <= item.light_x;
      y_mem[IW'(item.light_index)] <= item.light_y;
      r_mem[IW'(item.light_index)] <= item.light_radius;
      i_mem[IW'(item.light_index)] <= item.light_intensity;
    end
    if (rd_pending) begin
      lx <= x_mem[idx[IW-1:0]];
      ly <= y_mem[idx[IW-1:0]];
      lr <= r_mem[idx[IW-1:0]];
      li <= i_mem[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    mul_start <= 1'b0;
    term_start <= 1'b0;
    result_valid <= 1'b0;
    rd_pending <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && item.kind == KindQuery) begin
            px <= item.point_x;
            py <= item.point_y;
            sum <= (LevelW+IW+2)'(ambient_level);
            idx <= '0;
            n_lights <= (NW'(lights_in_use) > NW'(MAX_LIGHTS)) ?
                        NW'(MAX_LIGHTS) : NW'(lights_in_use);
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (idx >= n_lights) begin
            state <= S_OUT;
          end else if (!rd_pending) begin
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
          end
          if (rd_pending) begin
            state <= S_DX;
          end
        end
        S_DX: begin
          mul_a <= dx[DiffW-1] ? -dx : dx;
          mul_start <= 1'b1;
          state <= S_SQX;
        end
        S_SQX: begin
          if (mul_done) begin
            sq <= mul_p[SqW-1:0];
            mul_a <= dy[DiffW-1] ? -dy : dy;
            mul_start <= 1'b1;
            state <= S_DY;
          end
        end
        S_DY: begin
          if (mul_done) begin
            sq <= sq + mul_p[SqW-1:0];
            term_start <= 1'b1;
            state <= S_TERM;
          end
        end
        S_TERM: begin
          if (term_done) begin
            sum <= sum + (LevelW+IW+2)'(term);
            idx <= idx + 1'b1;
            sq <= '0;
            state <= S_NEXT;
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          if (sum > (LevelW+IW+2)'(OneLevel)) begin
            result <= '{brightness: OneLevel, saturated: 1'b1};
          end else begin
            result <= '{brightness: sum[LevelW-1:0], saturated: 1'b0};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
